/* rtl/reply_packet_deframer_lrc_macros.svh */
// Assertion helpers, clocked on i_clk and idle while i_rst_n is low.
`ifndef REPLY_PACKET_DEFRAMER_LRC_MACROS_SVH
`define REPLY_PACKET_DEFRAMER_LRC_MACROS_SVH

// Condition must hold at every clock edge.
`define RPD_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("deframer check failed");

// Consequent must hold in the cycle after the antecedent.
`define RPD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

/* rtl/rpdlrc_pkg.sv */
package rpdlrc_pkg;

    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned CFG_IDX_W = 8;
    localparam int unsigned OUT_DATA_W = 56;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOST_ADDRESS  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_COMMAND = 8'd3;

    // reset values
    localparam logic [BYTE_W-1:0] RST_HEADER_FIRST  = 8'h55;
    localparam logic [BYTE_W-1:0] RST_HEADER_SECOND = 8'hAA;
    localparam logic [BYTE_W-1:0] RST_HOST_ADDRESS  = 8'h01;
    localparam logic [BYTE_W-1:0] RST_ERROR_COMMAND = 8'hFA;

    // result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // end status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_LRC   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERR_REPLY = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] header_first;
        logic [BYTE_W-1:0] header_second;
        logic [BYTE_W-1:0] host_address;
        logic [BYTE_W-1:0] error_command;
    } t_cfg;

    typedef struct packed {
        logic                kind;
        logic [BYTE_W-1:0]   payload_byte;
        logic [BYTE_W-1:0]   payload_index;
        logic [BYTE_W-1:0]   sender_node;
        logic [BYTE_W-1:0]   command;
        logic [BYTE_W-1:0]   byte_count;
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   error_code;
    } t_result;

endpackage

/* rtl/rpdlrc_parser.sv */
module rpdlrc_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_step,
    input  logic [rpdlrc_pkg::BYTE_W-1:0]   i_byte,
    input  rpdlrc_pkg::t_cfg                i_cfg,
    output logic                            o_res_valid,
    output rpdlrc_pkg::t_result             o_res
);

    localparam logic [2:0] PH_HDR1    = 3'd0;
    localparam logic [2:0] PH_HDR2    = 3'd1;
    localparam logic [2:0] PH_ADDR    = 3'd2;
    localparam logic [2:0] PH_SENDER  = 3'd3;
    localparam logic [2:0] PH_COMMAND = 3'd4;
    localparam logic [2:0] PH_COUNT   = 3'd5;
    localparam logic [2:0] PH_PAYLOAD = 3'd6;
    localparam logic [2:0] PH_LRC     = 3'd7;

    logic [2:0]                      r_phase, n_phase;
    logic [rpdlrc_pkg::BYTE_W-1:0]   r_left, n_left;
    logic [rpdlrc_pkg::BYTE_W-1:0]   r_count, n_count;
    logic [rpdlrc_pkg::BYTE_W-1:0]   r_sender, n_sender;
    logic [rpdlrc_pkg::BYTE_W-1:0]   r_command, n_command;
    logic [rpdlrc_pkg::BYTE_W-1:0]   r_lrc, n_lrc;
    logic [rpdlrc_pkg::BYTE_W-1:0]   r_first, n_first;
    logic [rpdlrc_pkg::BYTE_W-1:0]   idx;

    assign idx = r_count - r_left;

    always_comb begin
        n_phase   = r_phase;
        n_left    = r_left;
        n_count   = r_count;
        n_sender  = r_sender;
        n_command = r_command;
        n_lrc     = r_lrc;
        n_first   = r_first;
        o_res_valid = 1'b0;
        o_res = '0;
        o_res.sender_node = r_sender;
        o_res.command     = r_command;
        o_res.byte_count  = r_count;
        case (r_phase)
            PH_HDR1: n_phase = (i_byte == i_cfg.header_first) ? PH_HDR2 : PH_HDR1;
            PH_HDR2: n_phase = (i_byte == i_cfg.header_second) ? PH_ADDR : PH_HDR1;
            PH_ADDR: n_phase = (i_byte == i_cfg.host_address) ? PH_SENDER : PH_HDR1;
            PH_SENDER: begin
                n_sender = i_byte;
                n_phase  = PH_COMMAND;
            end
            PH_COMMAND: begin
                n_command = i_byte;
                n_phase   = PH_COUNT;
            end
            PH_COUNT: begin
                n_count = i_byte;
                n_left  = i_byte;
                n_first = '0;
                n_lrc   = r_command ^ i_byte;
                n_phase = (i_byte != '0) ? PH_PAYLOAD : PH_LRC;
            end
            PH_PAYLOAD: begin
                if (idx == '0) begin
                    n_first = i_byte;
                end
                n_lrc  = r_lrc ^ i_byte;
                n_left = r_left - 8'd1;
                if (r_left == 8'd1) begin
                    n_phase = PH_LRC;
                end
                o_res_valid         = 1'b1;
                o_res.kind          = rpdlrc_pkg::KIND_PAYLOAD;
                o_res.payload_byte  = i_byte;
                o_res.payload_index = idx;
            end
            PH_LRC: begin
                n_phase     = PH_HDR1;
                o_res_valid = 1'b1;
                o_res.kind  = rpdlrc_pkg::KIND_END;
                // error reply wins over a bad check byte
                if (r_command == i_cfg.error_command) begin
                    o_res.status     = rpdlrc_pkg::ST_ERR_REPLY;
                    o_res.error_code = r_first;
                end else if (i_byte != r_lrc) begin
                    o_res.status = rpdlrc_pkg::ST_BAD_LRC;
                end else begin
                    o_res.status = rpdlrc_pkg::ST_OK;
                end
            end
            default: n_phase = PH_HDR1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HDR1;
            r_left    <= '0;
            r_count   <= '0;
            r_sender  <= '0;
            r_command <= '0;
            r_lrc     <= '0;
            r_first   <= '0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_left    <= n_left;
            r_count   <= n_count;
            r_sender  <= n_sender;
            r_command <= n_command;
            r_lrc     <= n_lrc;
            r_first   <= n_first;
        end
    end

endmodule

/* rtl/reply_packet_deframer_lrc.sv */
// Channel   Dir  Handshake                     Payload
// s (rx)    in   i_s_tvalid / o_s_tready       i_s_tdata: rx_byte
// m (res)   out  o_m_tvalid / i_m_tready       o_m_tdata, o_m_tuser: result_kind
// cfg       in   i_cfg_valid / o_cfg_ready     i_cfg_index, i_cfg_data
//
// One byte per cycle sustained while results are taken: input register, one pass of
// compares and an XOR in the parser, then the result register. Synchronous active-low
// reset clears the parser to the header hunt and loads the register defaults. A stalled
// result holds the pipe; the input register still takes one byte, and both stages move
// again as soon as the result is taken.
module reply_packet_deframer_lrc (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // rx byte stream
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    input  logic [7:0]                           i_s_tdata,   // [7:0] rx_byte
    // result stream
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // [7:0] payload_byte, [15:8] payload_index, [23:16] sender_node, [31:24] command,
    // [39:32] byte_count, [41:40] status, [49:42] error_code, [55:50] zero
    output logic [rpdlrc_pkg::OUT_DATA_W-1:0]    o_m_tdata,
    output logic                                 o_m_tuser,   // [0] result_kind
    // configuration writes
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [rpdlrc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [7:0]                           i_cfg_data
);

`include "reply_packet_deframer_lrc_macros.svh"

    rpdlrc_pkg::t_cfg    r_cfg;
    logic                r_in_valid;
    logic [7:0]          r_in_byte;
    logic                r_out_valid;
    rpdlrc_pkg::t_result r_out;
    logic                advance;
    logic                step;
    logic                res_valid;
    rpdlrc_pkg::t_result res;
    logic                out_pay;
    logic                out_clean;
    logic                out_code;

    // the user must write config only while idle; the block does not enforce it, so always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_first  <= rpdlrc_pkg::RST_HEADER_FIRST;
            r_cfg.header_second <= rpdlrc_pkg::RST_HEADER_SECOND;
            r_cfg.host_address  <= rpdlrc_pkg::RST_HOST_ADDRESS;
            r_cfg.error_command <= rpdlrc_pkg::RST_ERROR_COMMAND;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                rpdlrc_pkg::CFG_HEADER_FIRST:  r_cfg.header_first  <= i_cfg_data;
                rpdlrc_pkg::CFG_HEADER_SECOND: r_cfg.header_second <= i_cfg_data;
                rpdlrc_pkg::CFG_HOST_ADDRESS:  r_cfg.host_address  <= i_cfg_data;
                rpdlrc_pkg::CFG_ERROR_COMMAND: r_cfg.error_command <= i_cfg_data;
                default: ;  // unknown index: dropped
            endcase
        end
    end

    // result slot free, or emptying this cycle
    assign advance    = !r_out_valid || i_m_tready;
    assign step       = r_in_valid && advance;
    assign o_s_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
        end
    end

    rpdlrc_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_cfg       (r_cfg),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.kind;
    assign o_m_tdata  = {6'd0, r_out.error_code, r_out.status, r_out.byte_count,
                         r_out.command, r_out.sender_node, r_out.payload_index,
                         r_out.payload_byte};

    assign out_pay   = r_out_valid && (r_out.kind == rpdlrc_pkg::KIND_PAYLOAD);
    assign out_clean = (r_out.status == rpdlrc_pkg::ST_OK) && (r_out.error_code == 8'd0);
    assign out_code  = r_out_valid && (r_out.error_code != 8'd0);

    // payload items carry no status or error code
    `RPD_ASSERT_ALWAYS(a_payload_clean, !out_pay || out_clean)
    // an error code only comes with an error reply
    `RPD_ASSERT_ALWAYS(a_code_needs_err, !out_code || r_out.status == rpdlrc_pkg::ST_ERR_REPLY)
    // a blocked input byte stays in its register
    `RPD_ASSERT_NEXT(a_in_hold, r_in_valid && !advance, r_in_valid && $stable(r_in_byte))

endmodule

/* tb/reply_packet_deframer_lrc_checker.sv */
// Watches the rx, result and register-write channels of the deframer, keeps a
// byte-level model of the parser and compares every result item it sees.
module reply_packet_deframer_lrc_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    input  logic                              i_s_tready,
    input  logic [7:0]                        i_s_tdata,
    input  logic                              i_m_tvalid,
    input  logic                              i_m_tready,
    input  logic [rpdlrc_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic                              i_m_tuser,
    input  logic                              i_cfg_valid,
    input  logic                              i_cfg_ready,
    input  logic [rpdlrc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                        i_cfg_data,
    output int                                o_fail_count,
    output int                                o_pending
);

    localparam int MAX_PRINTED = 40;

    typedef enum logic [2:0] {
        HUNT_FIRST, HUNT_SECOND, HUNT_ADDR, TAKE_SENDER,
        TAKE_CMD, TAKE_COUNT, TAKE_PAYLOAD, TAKE_LRC
    } t_frame_phase;

    rpdlrc_pkg::t_cfg    regs;
    t_frame_phase        phase;
    logic [7:0]          left_n, cnt, snd, cmd, lrc, first_pl;
    rpdlrc_pkg::t_result due_q[$];
    int                  results_seen;

    task automatic flag_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
        if (o_fail_count < MAX_PRINTED)
            $display("mismatch at result %0d: %s got %0h want %0h",
                     results_seen, what, got, want);
        o_fail_count++;
    endtask

    // one rx byte through the parser model
    task automatic deframe_byte(input logic [7:0] b, output bit produced,
                                output rpdlrc_pkg::t_result r);
        logic [7:0] idx;
        produced = 1'b0;
        r = '0;
        case (phase)
            HUNT_FIRST:  phase = (b == regs.header_first)  ? HUNT_SECOND : HUNT_FIRST;
            HUNT_SECOND: phase = (b == regs.header_second) ? HUNT_ADDR   : HUNT_FIRST;
            HUNT_ADDR:   phase = (b == regs.host_address)  ? TAKE_SENDER : HUNT_FIRST;
            TAKE_SENDER: begin
                snd = b;
                phase = TAKE_CMD;
            end
            TAKE_CMD: begin
                cmd = b;
                phase = TAKE_COUNT;
            end
            TAKE_COUNT: begin
                cnt = b;
                left_n = b;
                first_pl = '0;
                lrc = cmd ^ b;
                phase = (b != '0) ? TAKE_PAYLOAD : TAKE_LRC;
            end
            TAKE_PAYLOAD: begin
                idx = cnt - left_n;
                if (idx == '0)
                    first_pl = b;
                lrc = lrc ^ b;
                left_n = left_n - 8'd1;
                if (left_n == '0)
                    phase = TAKE_LRC;
                r.kind = rpdlrc_pkg::KIND_PAYLOAD;
                r.payload_byte = b;
                r.payload_index = idx;
                produced = 1'b1;
            end
            default: begin
                phase = HUNT_FIRST;
                r.kind = rpdlrc_pkg::KIND_END;
                // error reply wins over a wrong LRC
                if (cmd == regs.error_command) begin
                    r.status = rpdlrc_pkg::ST_ERR_REPLY;
                    r.error_code = first_pl;
                end else if (b != lrc) begin
                    r.status = rpdlrc_pkg::ST_BAD_LRC;
                end else begin
                    r.status = rpdlrc_pkg::ST_OK;
                end
                produced = 1'b1;
            end
        endcase
        if (produced) begin
            r.sender_node = snd;
            r.command = cmd;
            r.byte_count = cnt;
        end
    endtask

    task automatic check_result(input logic [rpdlrc_pkg::OUT_DATA_W-1:0] d,
                                input logic kind);
        rpdlrc_pkg::t_result want;
        results_seen++;
        if (due_q.size() == 0) begin
            flag_mismatch("result with none due, kind", {7'b0, kind}, 8'h00);
            return;
        end
        want = due_q.pop_front();
        if (kind !== want.kind)
            flag_mismatch("result_kind", {7'b0, kind}, {7'b0, want.kind});
        if (d[7:0] !== want.payload_byte)
            flag_mismatch("payload_byte", d[7:0], want.payload_byte);
        if (d[15:8] !== want.payload_index)
            flag_mismatch("payload_index", d[15:8], want.payload_index);
        if (d[23:16] !== want.sender_node)
            flag_mismatch("sender_node", d[23:16], want.sender_node);
        if (d[31:24] !== want.command)
            flag_mismatch("command", d[31:24], want.command);
        if (d[39:32] !== want.byte_count)
            flag_mismatch("byte_count", d[39:32], want.byte_count);
        if (d[41:40] !== want.status)
            flag_mismatch("status", {6'b0, d[41:40]}, {6'b0, want.status});
        if (d[49:42] !== want.error_code)
            flag_mismatch("error_code", d[49:42], want.error_code);
        if (d[55:50] !== 6'b0)
            flag_mismatch("pad bits", {2'b0, d[55:50]}, 8'h00);
    endtask

    always @(posedge i_clk) begin
        bit                  produced;
        rpdlrc_pkg::t_result r;
        if (!i_rst_n) begin
            regs <= '{rpdlrc_pkg::RST_HEADER_FIRST, rpdlrc_pkg::RST_HEADER_SECOND,
                      rpdlrc_pkg::RST_HOST_ADDRESS, rpdlrc_pkg::RST_ERROR_COMMAND};
            phase = HUNT_FIRST;
            left_n = '0;
            cnt = '0;
            snd = '0;
            cmd = '0;
            lrc = '0;
            first_pl = '0;
            due_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    rpdlrc_pkg::CFG_HEADER_FIRST:  regs.header_first  <= i_cfg_data;
                    rpdlrc_pkg::CFG_HEADER_SECOND: regs.header_second <= i_cfg_data;
                    rpdlrc_pkg::CFG_HOST_ADDRESS:  regs.host_address  <= i_cfg_data;
                    rpdlrc_pkg::CFG_ERROR_COMMAND: regs.error_command <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready)
                check_result(i_m_tdata, i_m_tuser);
            if (i_s_tvalid && i_s_tready) begin
                deframe_byte(i_s_tdata, produced, r);
                if (produced)
                    due_q.push_back(r);
            end
        end
        o_pending <= due_q.size();
    end

endmodule

/* tb/testbench.sv */
// Stimulus and verdict for the reply deframer. The checker beside the block
// does all prediction; this module only makes traffic and decides pass/fail.
module testbench;

    localparam int HALF_PERIOD  = 10;
    localparam int RESET_CYCLES = 11;
    localparam int LATENCY      = 2;       // accept to result, per the block
    localparam int HOLD_CYCLES  = 300;     // receiver hold-off under pressure
    localparam int LIMIT_CYCLES = 1000000;

    // indexes outside the register map; writes there must change nothing
    localparam logic [rpdlrc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO =
        rpdlrc_pkg::CFG_ERROR_COMMAND + 8'd1;
    localparam logic [rpdlrc_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = '1;

    logic                              clk       = 1'b0;
    logic                              rst_n     = 1'b0;
    logic                              s_tvalid  = 1'b0;
    logic                              s_tready;
    logic [7:0]                        s_tdata   = '0;
    logic                              m_tvalid;
    logic                              m_tready  = 1'b0;
    logic [rpdlrc_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                              m_tuser;
    logic                              cfg_valid = 1'b0;
    logic                              cfg_ready;
    logic [rpdlrc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [7:0]                        cfg_data  = '0;

    int fail_count;
    int pending;

    // stimulus-side view of the registers, used only to build framed packets
    logic [7:0] cur_hf   = rpdlrc_pkg::RST_HEADER_FIRST;
    logic [7:0] cur_hs   = rpdlrc_pkg::RST_HEADER_SECOND;
    logic [7:0] cur_host = rpdlrc_pkg::RST_HOST_ADDRESS;
    logic [7:0] cur_err  = rpdlrc_pkg::RST_ERROR_COMMAND;

    bit s_burst;                 // sender offers back to back while set
    int hold_asked, hold_served; // receiver hold-off handshake between processes

    int unsigned bytes_in, noise_bytes, packets, err_replies, bad_lrcs;
    int unsigned cfg_writes, settings;

    always #HALF_PERIOD clk = ~clk;

    reply_packet_deframer_lrc uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    reply_packet_deframer_lrc_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tuser    (m_tuser),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] other_than(input logic [7:0] avoid);
        logic [7:0] b;
        b = 8'($urandom);
        if (b == avoid)
            b = b ^ 8'h01;
        return b;
    endfunction

    // Offer one rx item and return once it is taken. tvalid stays high on exit
    // so back-to-back items never drop it within a step.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = s_burst ? 0 : idle_len();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        bytes_in++;
    endtask

    // Full frame with the current sync and address bytes; payload is random.
    task automatic send_packet(input bit err_reply, input bit bad_lrc,
                               input logic [7:0] count);
        logic [7:0] cmd, lrc, b;
        cmd = err_reply ? cur_err : 8'($urandom);
        send_byte(cur_hf);
        send_byte(cur_hs);
        send_byte(cur_host);
        send_byte(8'($urandom));
        send_byte(cmd);
        send_byte(count);
        lrc = cmd ^ count;
        repeat (count) begin
            b = 8'($urandom);
            lrc = lrc ^ b;
            send_byte(b);
        end
        if (bad_lrc)
            lrc = lrc ^ 8'($urandom_range(1, 255));
        send_byte(lrc);
        packets++;
        if (cmd == cur_err)
            err_replies++;
        else if (bad_lrc)
            bad_lrcs++;
    endtask

    // Mostly well-formed frames; the rest are broken hunts and line noise.
    task automatic run_random(input int unsigned target);
        int unsigned start, pick, n;
        logic [7:0]  cnt;
        start = bytes_in - noise_bytes;
        while (bytes_in - noise_bytes - start < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                if ($urandom_range(0, 9) < 8)
                    cnt = 8'($urandom_range(0, 6));
                else
                    cnt = 8'($urandom_range(7, 24));
                send_packet($urandom_range(0, 5) == 0, $urandom_range(0, 3) == 0, cnt);
            end else if (pick < 85) begin
                // header seen, then a wrong second header or a foreign address
                send_byte(cur_hf);
                if ($urandom_range(0, 1) == 0) begin
                    send_byte(other_than(cur_hs));
                end else begin
                    send_byte(cur_hs);
                    send_byte(other_than(cur_host));
                end
            end else begin
                n = $urandom_range(1, 4);
                noise_bytes += n;
                // noise that happens to look like a header is allowed now and then
                repeat (n)
                    send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : other_than(cur_hf));
            end
        end
    endtask

    // Dropping cfg_valid after each write keeps it to one update per step.
    task automatic cfg_write(input logic [rpdlrc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        cfg_writes++;
        case (idx)
            rpdlrc_pkg::CFG_HEADER_FIRST:  cur_hf   = val;
            rpdlrc_pkg::CFG_HEADER_SECOND: cur_hs   = val;
            rpdlrc_pkg::CFG_HOST_ADDRESS:  cur_host = val;
            rpdlrc_pkg::CFG_ERROR_COMMAND: cur_err  = val;
            default: ;
        endcase
    endtask

    task automatic set_regs(input logic [7:0] hf, input logic [7:0] hs,
                            input logic [7:0] host, input logic [7:0] err);
        cfg_write(rpdlrc_pkg::CFG_HEADER_FIRST, hf);
        cfg_write(rpdlrc_pkg::CFG_HEADER_SECOND, hs);
        cfg_write(rpdlrc_pkg::CFG_HOST_ADDRESS, host);
        cfg_write(rpdlrc_pkg::CFG_ERROR_COMMAND, err);
        settings++;
    endtask

    // Idle the sender, let every due result out, then cover the pipe latency,
    // since hunt bytes leave nothing behind in the checker to wait on.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    // Result side: random ready with gaps, plus a long hold-off on request.
    initial begin : receiver
        int unsigned gap;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_served != hold_asked) begin
                hold_served = hold_asked;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end else begin
                gap = idle_len();
                if (gap != 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
                m_tready <= 1'b1;
                repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 64 : 8))
                    @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        logic [7:0] dq[$];
        settings = 1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed, reset register values.
        dq = '{
            // empty payload goes straight to LRC; sender at its top value
            rpdlrc_pkg::RST_HEADER_FIRST, rpdlrc_pkg::RST_HEADER_SECOND,
            rpdlrc_pkg::RST_HOST_ADDRESS, 8'hFF, 8'h00, 8'h00, 8'h00,
            // repeated first header fails as second header and is not rechecked,
            // so the sync and address bytes after it are dropped
            rpdlrc_pkg::RST_HEADER_FIRST, rpdlrc_pkg::RST_HEADER_FIRST,
            rpdlrc_pkg::RST_HEADER_SECOND, rpdlrc_pkg::RST_HOST_ADDRESS,
            // error reply with a wrong LRC: error status wins, code from payload 0
            rpdlrc_pkg::RST_HEADER_FIRST, rpdlrc_pkg::RST_HEADER_SECOND,
            rpdlrc_pkg::RST_HOST_ADDRESS, 8'h00, rpdlrc_pkg::RST_ERROR_COMMAND,
            8'h02, 8'hFF, 8'h00, 8'h5A,
            // error reply with no payload: code is zero
            rpdlrc_pkg::RST_HEADER_FIRST, rpdlrc_pkg::RST_HEADER_SECOND,
            rpdlrc_pkg::RST_HOST_ADDRESS, 8'h7E, rpdlrc_pkg::RST_ERROR_COMMAND,
            8'h00, rpdlrc_pkg::RST_ERROR_COMMAND
        };
        foreach (dq[i])
            send_byte(dq[i]);
        packets += 3;
        err_replies += 2;
        wait_drained();

        // random register values, and a write to an unmapped index
        set_regs(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        cfg_write(CFG_IDX_SPARE_LO, 8'($urandom));
        run_random(80);
        wait_drained();

        // all registers at zero
        set_regs(8'h00, 8'h00, 8'h00, 8'h00);
        run_random(60);
        wait_drained();

        // all registers at the top value; one frame with the longest payload
        set_regs(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        cfg_write(CFG_IDX_SPARE_HI, 8'($urandom));
        send_packet(1'b0, 1'b0, 8'hFF);
        run_random(20);
        wait_drained();

        // equal sync bytes; sender runs flat out while the receiver holds off
        cur_hf = 8'($urandom);
        set_regs(cur_hf, cur_hf, 8'($urandom), 8'($urandom));
        s_burst = 1'b1;
        hold_asked++;
        wait (hold_served == hold_asked);
        run_random(100);
        s_burst = 1'b0;
        wait_drained();

        // back to the reset values
        set_regs(rpdlrc_pkg::RST_HEADER_FIRST, rpdlrc_pkg::RST_HEADER_SECOND,
                 rpdlrc_pkg::RST_HOST_ADDRESS, rpdlrc_pkg::RST_ERROR_COMMAND);
        run_random(50);
        wait_drained();

        $display("covered %0d rx items (%0d noise), %0d frames: %0d error replies, %0d bad LRC",
                 bytes_in, noise_bytes, packets, err_replies, bad_lrcs);
        $display("%0d register writes over %0d settings, one %0d-cycle result hold-off",
                 cfg_writes, settings, HOLD_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("timeout with %0d results still due", pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule
